// ===== hw/rtl/lcf_pkg.sv =====
// shared types, register codes and reset values for the comet trail fader
package lcf_pkg;

    localparam int PIXEL_COUNT_DEF = 64;

    // config register indexes
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_FADE_DELAY = 3'd1;
    localparam logic [2:0] REG_RING_SPEED = 3'd2;
    localparam logic [2:0] REG_FADE_RATE  = 3'd3;
    localparam logic [2:0] REG_SEED_RED   = 3'd4;
    localparam logic [2:0] REG_SEED_GREEN = 3'd5;
    localparam logic [2:0] REG_SEED_BLUE  = 3'd6;

    localparam logic        ENABLE_RST     = 1'b1;
    localparam logic [7:0]  FADE_DELAY_RST = 8'd2;
    localparam logic [7:0]  RING_SPEED_RST = 8'd6;
    localparam logic [15:0] FADE_RATE_RST  = 16'd64553;

    // 1.0 in unsigned 8.8
    localparam logic [15:0] ONE_FIX = 16'h0100;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEED_RD,
        S_SEED_WR,
        S_FADE_RD,
        S_FADE_WR
    } t_state;

    typedef struct packed {
        logic clr_wr;     // write zero at walk index, advance
        logic tick_step;  // accepted live tick: update counters and head
        logic seed_rd;    // read head pixel
        logic seed_wr;    // seed head pixel if it is dim
        logic fade_rd;    // read pixel at walk index
        logic fade_wr;    // report, write back faded pixel, advance
    } t_cmd;

    typedef struct packed {
        logic tick_en;    // tick bit set and block enabled
        logic head_move;  // this tick moves the head
        logic fade_due;   // this tick runs a fade pass
        logic pass_pend;  // fade pass pending after seeding
        logic idx_last;   // walk index on last pixel
        logic out_free;   // output register can take a new result
    } t_status;

endpackage

// ===== hw/rtl/led_comet_trail_fader.sv =====
// top level of the comet trail fader for a ring of rgb pixels
//
// input stream: one transfer per animation tick, s_axis_tdata[0] is the tick
// bit; a transfer with tick low, or any transfer while disabled, is a no-op
// output stream: on a fade pass one transfer per pixel in index order with
// tlast on the final pixel; tdata carries pixel index, red, green, blue
// config: i_cfg_we writes i_cfg_data into the register at i_cfg_index;
// the user writes only while the block is idle, which the block does not
// enforce; indexes past seed_blue are ignored
// sequence: a tick is taken in the idle state; a head move adds a read, then
// a conditional seed write of the pixel store; a fade pass reads each pixel
// from the store, then writes it back and loads the output register, one
// pixel after the other
// stall: when the receiver holds tready low the pass waits on the output
// register and s_axis_tready stays low until the pass has finished
// reset: i_rst_n is synchronous active low; afterwards the pixel store is
// swept to zero one pixel per cycle from index zero to the last, with
// s_axis_tready low; config writes are taken during the sweep
module led_comet_trail_fader #(
    parameter int PIXEL_COUNT = lcf_pkg::PIXEL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // tick stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
    // pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] pixel_index, [13:6] red,
                                        // [21:14] green, [29:22] blue, [31:30] zero
    output logic        m_axis_tlast
);

    lcf_pkg::t_cmd    cmd;
    lcf_pkg::t_status status;

    // upper tick bits are padding
    logic tick_bit;
    assign tick_bit = s_axis_tdata[0];

    lcf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    lcf_datapath #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_bit),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/lcf_ram.sv =====
// generic single write port ram with registered read
module lcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/lcf_ctrl.sv =====
// sequencer for clearing, head seeding and fade passes
module lcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lcf_pkg::t_status i_status,
    output lcf_pkg::t_cmd    o_cmd
);

    lcf_pkg::t_state r_state;
    lcf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcf_pkg::S_CLEAR: begin
                if (i_status.idx_last) begin
                    n_state = lcf_pkg::S_IDLE;
                end
            end
            lcf_pkg::S_IDLE: begin
                if (i_in_valid && i_status.tick_en) begin
                    priority if (i_status.head_move) begin
                        n_state = lcf_pkg::S_SEED_RD;
                    end else if (i_status.fade_due) begin
                        n_state = lcf_pkg::S_FADE_RD;
                    end else begin
                        n_state = lcf_pkg::S_IDLE;
                    end
                end
            end
            lcf_pkg::S_SEED_RD: n_state = lcf_pkg::S_SEED_WR;
            lcf_pkg::S_SEED_WR: begin
                n_state = i_status.pass_pend ? lcf_pkg::S_FADE_RD : lcf_pkg::S_IDLE;
            end
            lcf_pkg::S_FADE_RD: n_state = lcf_pkg::S_FADE_WR;
            lcf_pkg::S_FADE_WR: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? lcf_pkg::S_IDLE : lcf_pkg::S_FADE_RD;
                end
            end
            default: n_state = lcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lcf_pkg::S_CLEAR: o_cmd.clr_wr = 1'b1;
            lcf_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.tick_step = i_in_valid && i_status.tick_en;
            end
            lcf_pkg::S_SEED_RD: o_cmd.seed_rd = 1'b1;
            lcf_pkg::S_SEED_WR: o_cmd.seed_wr = 1'b1;
            lcf_pkg::S_FADE_RD: o_cmd.fade_rd = 1'b1;
            lcf_pkg::S_FADE_WR: o_cmd.fade_wr = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // the ready is only raised where a tick can be taken
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_cmd.seed_rd || o_cmd.fade_rd || o_cmd.clr_wr))
        else $error("input ready outside idle");
    // a seed read is always followed by the seed decision
    a_seed_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.seed_rd |=> o_cmd.seed_wr)
        else $error("seed read not followed by seed write");

endmodule

// ===== hw/rtl/lcf_datapath.sv =====
// config registers, counters, pixel store and output register
module lcf_datapath #(
    parameter int PIXEL_COUNT = lcf_pkg::PIXEL_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_tick,
    input  lcf_pkg::t_cmd    i_cmd,
    output lcf_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_out_data,
    output logic             o_out_last
);

    localparam int IDX_W = $clog2(PIXEL_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

    logic        r_enable;
    logic [7:0]  r_fade_delay;
    logic [7:0]  r_ring_speed;
    logic [15:0] r_fade_rate;
    logic [7:0]  r_seed_red;
    logic [7:0]  r_seed_green;
    logic [7:0]  r_seed_blue;

    logic [IDX_W-1:0] r_head;
    logic [15:0]      r_move_cnt;
    logic [8:0]       r_fade_cnt;
    logic             r_pass_pend;
    logic [IDX_W-1:0] r_idx;

    logic        r_out_valid;
    logic [29:0] r_out_data;
    logic        r_out_last;

    logic [15:0] head_period;
    logic [15:0] n_move_cnt;
    logic        head_move;
    logic        fade_due;
    logic        idx_last;
    logic        out_free;

    logic [47:0]      rd_word;
    logic [15:0]      rd_red, rd_green, rd_blue;
    logic [31:0]      prod_red, prod_green, prod_blue;
    logic [15:0]      fd_red, fd_green, fd_blue;
    logic             px_dim, px_lit;
    logic             ram_we;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [47:0]      ram_wr_data;
    logic [IDX_W+5:0] idx_ext;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= lcf_pkg::ENABLE_RST;
            r_fade_delay <= lcf_pkg::FADE_DELAY_RST;
            r_ring_speed <= lcf_pkg::RING_SPEED_RST;
            r_fade_rate  <= lcf_pkg::FADE_RATE_RST;
            r_seed_red   <= '0;
            r_seed_green <= '0;
            r_seed_blue  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcf_pkg::REG_ENABLE:     r_enable     <= i_cfg_data[0];
                lcf_pkg::REG_FADE_DELAY: r_fade_delay <= i_cfg_data[7:0];
                lcf_pkg::REG_RING_SPEED: r_ring_speed <= i_cfg_data[7:0];
                lcf_pkg::REG_FADE_RATE:  r_fade_rate  <= i_cfg_data;
                lcf_pkg::REG_SEED_RED:   r_seed_red   <= i_cfg_data[7:0];
                lcf_pkg::REG_SEED_GREEN: r_seed_green <= i_cfg_data[7:0];
                lcf_pkg::REG_SEED_BLUE:  r_seed_blue  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // tick counters
    assign head_period = 16'(r_ring_speed) * 16'(r_fade_delay);
    assign n_move_cnt  = r_move_cnt + 16'd1;
    assign head_move   = n_move_cnt >= head_period;
    assign fade_due    = r_fade_cnt > {1'b0, r_fade_delay};
    assign idx_last    = r_idx == LAST_IDX;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_move_cnt  <= '0;
            r_fade_cnt  <= '0;
            r_pass_pend <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.tick_step) begin
                r_move_cnt  <= head_move ? 16'd0 : n_move_cnt;
                r_pass_pend <= fade_due;
                // restart at one, then the usual increment
                r_fade_cnt  <= fade_due ? 9'd2 : r_fade_cnt + 9'd1;
                r_idx       <= '0;
                if (head_move) begin
                    r_head <= (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
                end
            end
            if (i_cmd.clr_wr || i_cmd.fade_wr) begin
                r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    // pixel word: red low, then green, then blue
    assign rd_red   = rd_word[15:0];
    assign rd_green = rd_word[31:16];
    assign rd_blue  = rd_word[47:32];

    assign px_dim = rd_red < lcf_pkg::ONE_FIX && rd_green < lcf_pkg::ONE_FIX
                    && rd_blue < lcf_pkg::ONE_FIX;
    assign px_lit = rd_red > lcf_pkg::ONE_FIX || rd_green > lcf_pkg::ONE_FIX
                    || rd_blue > lcf_pkg::ONE_FIX;

    assign prod_red   = 32'(rd_red) * 32'(r_fade_rate);
    assign prod_green = 32'(rd_green) * 32'(r_fade_rate);
    assign prod_blue  = 32'(rd_blue) * 32'(r_fade_rate);

    // channels at or below one clear, which also clears a dim pixel
    assign fd_red   = (rd_red > lcf_pkg::ONE_FIX) ? prod_red[31:16] : 16'd0;
    assign fd_green = (rd_green > lcf_pkg::ONE_FIX) ? prod_green[31:16] : 16'd0;
    assign fd_blue  = (rd_blue > lcf_pkg::ONE_FIX) ? prod_blue[31:16] : 16'd0;

    always_comb begin
        ram_we      = 1'b0;
        ram_wr_data = '0;
        ram_wr_addr = r_idx;
        priority if (i_cmd.seed_wr) begin
            ram_we      = px_dim;
            ram_wr_addr = r_head;
            ram_wr_data = {r_seed_blue, 8'h00, r_seed_green, 8'h00, r_seed_red, 8'h00};
        end else if (i_cmd.fade_wr) begin
            ram_we      = 1'b1;
            ram_wr_data = {fd_blue, fd_green, fd_red};
        end else if (i_cmd.clr_wr) begin
            ram_we      = 1'b1;
        end else begin
            ram_we      = 1'b0;
        end
    end

    assign ram_rd_addr = i_cmd.seed_rd ? r_head : r_idx;

    lcf_ram #(
        .WIDTH(48),
        .DEPTH(PIXEL_COUNT)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (i_cmd.seed_rd || i_cmd.fade_rd),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(rd_word)
    );

    // output register
    assign idx_ext = (IDX_W + 6)'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fade_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fade_wr) begin
            r_out_last <= idx_last;
            if (px_lit) begin
                r_out_data <= {rd_blue[15:8], rd_green[15:8], rd_red[15:8], idx_ext[5:0]};
            end else begin
                r_out_data <= {24'd0, idx_ext[5:0]};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {2'b00, r_out_data};
    assign o_out_last  = r_out_last;

    always_comb begin
        o_status.tick_en   = i_tick && r_enable;
        o_status.head_move = head_move;
        o_status.fade_due  = fade_due;
        o_status.pass_pend = r_pass_pend;
        o_status.idx_last  = idx_last;
        o_status.out_free  = out_free;
    end

    // loading a busy output register would drop a result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fade_wr |-> (!r_out_valid || i_out_ready))
        else $error("output register overrun");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("head pixel out of range");
    a_fade_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_step && fade_due) |=> (r_fade_cnt == 9'd2 && r_pass_pend))
        else $error("fade counter did not restart");
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_step |=> r_idx == '0)
        else $error("pixel walk does not start at zero");

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the comet trail fader: tick stream in, pixel stream out
module tb;

    localparam int PIXELS        = lcf_pkg::PIXEL_COUNT_DEF;
    localparam int RANDOM_TICKS  = 440;    // least tick transfers in the random part
    localparam int CHUNK_TICKS   = 40;     // tick transfers per enabled random setting
    localparam int SETTLE_CYCLES = 8;      // head move or pass write-back tail
    localparam int HOLD_CYCLES   = 400;    // long receiver stall
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // one pixel transfer as it should leave the block
    typedef struct packed {
        logic [5:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       is_last;
    } t_pixel;

    // dut inputs, all driven to known values from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = lcf_pkg::REG_ENABLE;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [0] tick, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [5:0] pixel_index, [13:6] red,
                                        // [21:14] green, [29:22] blue
    logic        m_axis_tlast;

    // stimulus and scoreboard
    bit     pending_ticks[$];
    t_pixel expected_pixels[$];
    int     mismatch_count = 0;
    int     send_gap = 0;
    int     take_gap = 0;
    bit     hold_armed = 1'b0;
    logic   rx_hold = 1'b0;

    // predicted settings
    logic        cfg_enable;
    logic [7:0]  cfg_delay;
    logic [7:0]  cfg_speed;
    logic [15:0] cfg_rate;
    logic [7:0]  seed_r, seed_g, seed_b;

    // predicted ring state, channels in unsigned 8.8
    logic [15:0] pix_r [PIXELS];
    logic [15:0] pix_g [PIXELS];
    logic [15:0] pix_b [PIXELS];
    logic [5:0]  head_pos;
    logic [15:0] move_cnt;
    logic [8:0]  fade_cnt;

    led_comet_trail_fader dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void fader_reset();
        cfg_enable = lcf_pkg::ENABLE_RST;
        cfg_delay  = lcf_pkg::FADE_DELAY_RST;
        cfg_speed  = lcf_pkg::RING_SPEED_RST;
        cfg_rate   = lcf_pkg::FADE_RATE_RST;
        seed_r     = '0;
        seed_g     = '0;
        seed_b     = '0;
        for (int i = 0; i < PIXELS; i++) begin
            pix_r[i] = '0;
            pix_g[i] = '0;
            pix_b[i] = '0;
        end
        head_pos = '0;
        move_cnt = '0;
        fade_cnt = '0;
    endfunction

    // register writes are masked to the register width, unknown index dropped
    function automatic void store_setting(logic [2:0] idx, logic [15:0] val);
        case (idx)
            lcf_pkg::REG_ENABLE:     cfg_enable = val[0];
            lcf_pkg::REG_FADE_DELAY: cfg_delay  = val[7:0];
            lcf_pkg::REG_RING_SPEED: cfg_speed  = val[7:0];
            lcf_pkg::REG_FADE_RATE:  cfg_rate   = val;
            lcf_pkg::REG_SEED_RED:   seed_r     = val[7:0];
            lcf_pkg::REG_SEED_GREEN: seed_g     = val[7:0];
            lcf_pkg::REG_SEED_BLUE:  seed_b     = val[7:0];
            default: ;
        endcase
    endfunction

    // one channel after a pass: scaled by the rate if above 1.0, else cleared
    function automatic logic [15:0] dim_channel(logic [15:0] v);
        int unsigned prod;
        prod = v * cfg_rate;
        return (v > lcf_pkg::ONE_FIX) ? prod[31:16] : 16'd0;
    endfunction

    // one accepted tick transfer: head move and seeding, then maybe a fade pass
    function automatic void advance_frame(logic tick);
        int unsigned period;
        logic [15:0] r, g, b;
        t_pixel px;
        if (!tick || !cfg_enable) return;

        move_cnt = move_cnt + 16'd1;
        period = cfg_speed * cfg_delay;
        // a zero period moves the head on every tick
        if (32'(move_cnt) >= period) begin
            move_cnt = '0;
            head_pos = (int'(head_pos) == PIXELS - 1) ? 6'd0 : head_pos + 6'd1;
            // seed only a head pixel that is dark on all channels
            if (pix_r[head_pos] < lcf_pkg::ONE_FIX && pix_g[head_pos] < lcf_pkg::ONE_FIX &&
                pix_b[head_pos] < lcf_pkg::ONE_FIX) begin
                pix_r[head_pos] = {seed_r, 8'h00};
                pix_g[head_pos] = {seed_g, 8'h00};
                pix_b[head_pos] = {seed_b, 8'h00};
            end
        end

        if (fade_cnt > {1'b0, cfg_delay}) begin
            fade_cnt = 9'd1;
            for (int i = 0; i < PIXELS; i++) begin
                r = pix_r[i];
                g = pix_g[i];
                b = pix_b[i];
                px.idx     = i[5:0];
                px.is_last = (i == PIXELS - 1);
                if (r > lcf_pkg::ONE_FIX || g > lcf_pkg::ONE_FIX || b > lcf_pkg::ONE_FIX) begin
                    px.red   = r[15:8];
                    px.green = g[15:8];
                    px.blue  = b[15:8];
                    pix_r[i] = dim_channel(r);
                    pix_g[i] = dim_channel(g);
                    pix_b[i] = dim_channel(b);
                end else begin
                    // pixel with no channel above 1.0 shows black and is wiped
                    px.red   = '0;
                    px.green = '0;
                    px.blue  = '0;
                    pix_r[i] = '0;
                    pix_g[i] = '0;
                    pix_b[i] = '0;
                end
                expected_pixels.push_back(px);
            end
        end
        fade_cnt = fade_cnt + 9'd1;
    endfunction

    // ---------------------------------------------------------------
    // random helpers
    // ---------------------------------------------------------------

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_seed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return 8'hFF;
        if (roll < 35) return 8'h00;
        if (roll < 45) return 8'h01;
        if (roll < 50) return 8'h02;
        return 8'($urandom);
    endfunction

    function automatic int check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // ---------------------------------------------------------------
    // tick driver, also feeds the predictor on every accepted transfer
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fader_reset();
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap = 0;
        end else begin
            // settings are only written while nothing is in flight
            if (i_cfg_we) begin
                store_setting(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_frame(s_axis_tdata[0]);
            end
            // a new transfer may be offered once the current one is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, pending_ticks.pop_front()};
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // pixel monitor with random back-pressure
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            take_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel transfer with none expected: tdata %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    mismatch_count += check_field("pixel_index", want.idx,
                                                  m_axis_tdata[5:0]);
                    mismatch_count += check_field("red", want.red, m_axis_tdata[13:6]);
                    mismatch_count += check_field("green", want.green,
                                                  m_axis_tdata[21:14]);
                    mismatch_count += check_field("blue", want.blue,
                                                  m_axis_tdata[29:22]);
                    mismatch_count += check_field("last", want.is_last, m_axis_tlast);
                end
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap = take_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                take_gap = pick_gap();
            end
        end
    end

    // long receiver stall once a pass is under way, so the tick input backs up
    initial begin
        wait (hold_armed);
        do @(posedge i_clk); while (!m_axis_tvalid);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // queue n ticks taken from pattern, lowest bit first
    task automatic send_ticks(logic [31:0] pattern, int n);
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            pending_ticks.push_back(pattern[i]);
        end
    endtask

    // wait until every tick is taken and every pixel seen, then let the tail finish
    task automatic settle();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int sent_total;
        int chunk;
        int roll;
        bit en;
        bit t;
        logic [7:0]  delay_v;
        logic [7:0]  speed_v;
        logic [15:0] rate_v;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bright white comet, rate at full scale, head moves on every live tick and fades on each after the first;
        // junk in the upper data bits must be masked off
        write_reg(lcf_pkg::REG_SEED_RED,   16'hA5FF);
        write_reg(lcf_pkg::REG_SEED_GREEN, 16'h00FF);
        write_reg(lcf_pkg::REG_SEED_BLUE,  16'h5AFF);
        write_reg(lcf_pkg::REG_FADE_RATE,  16'hFFFF);
        write_reg(lcf_pkg::REG_FADE_DELAY, 16'h0000);
        write_reg(lcf_pkg::REG_RING_SPEED, 16'h0001);
        send_ticks(32'b11011, 5);
        settle();

        // zero rate wipes the trail; a channel at exactly 1.0 next to a brighter one
        write_reg(lcf_pkg::REG_FADE_RATE,  16'h0000);
        write_reg(lcf_pkg::REG_SEED_RED,   16'h0001);
        write_reg(lcf_pkg::REG_SEED_GREEN, 16'h0002);
        write_reg(lcf_pkg::REG_SEED_BLUE,  16'h0000);
        send_ticks(32'b11, 2);
        settle();
        // all channels at exactly 1.0 are not lit: shown black and cleared
        write_reg(lcf_pkg::REG_SEED_GREEN, 16'h0001);
        write_reg(lcf_pkg::REG_SEED_BLUE,  16'h0001);
        send_ticks(32'b11, 2);
        settle();

        // disabled: ticks are ignored (enable bit taken from bit 0 only)
        write_reg(lcf_pkg::REG_ENABLE, 16'hFFFE);
        send_ticks(32'b111, 3);
        settle();
        write_reg(lcf_pkg::REG_ENABLE, 16'h0001);

        // zero ring speed gives a zero head period
        write_reg(lcf_pkg::REG_FADE_DELAY, 16'h0005);
        write_reg(lcf_pkg::REG_RING_SPEED, 16'h0000);
        write_reg(lcf_pkg::REG_SEED_RED,   16'h0080);
        write_reg(lcf_pkg::REG_SEED_GREEN, 16'h0040);
        write_reg(lcf_pkg::REG_SEED_BLUE,  16'h0020);
        write_reg(lcf_pkg::REG_FADE_RATE,  16'h8000);
        send_ticks(32'h7F, 7);
        settle();

        // unused index is dropped; slowest delay and speed
        write_reg(REG_UNUSED,              16'hFFFF);
        write_reg(lcf_pkg::REG_FADE_DELAY, 16'h00FF);
        write_reg(lcf_pkg::REG_RING_SPEED, 16'h00FF);
        send_ticks(32'b11, 2);
        settle();

        // random part: a fresh setting per chunk, mostly live ticks with some no-ops
        hold_armed = 1'b1;
        sent_total = 0;
        chunk = 0;
        while (sent_total < RANDOM_TICKS) begin
            en = (chunk == 0) || ($urandom_range(0, 7) != 0);

            roll = $urandom_range(0, 99);
            if (chunk == 0)    delay_v = 8'd1;
            else if (roll < 45) delay_v = 8'($urandom_range(0, 2));
            else if (roll < 80) delay_v = 8'($urandom_range(3, 8));
            else if (roll < 90) delay_v = 8'hFF;
            else                delay_v = 8'($urandom);

            roll = $urandom_range(0, 99);
            if (roll < 15)      speed_v = 8'd0;
            else if (roll < 30) speed_v = 8'd1;
            else if (roll < 40) speed_v = 8'hFF;
            else                speed_v = 8'($urandom_range(2, 12));

            roll = $urandom_range(0, 99);
            if (roll < 25)      rate_v = 16'hFFFF;
            else if (roll < 35) rate_v = 16'h0000;
            else                rate_v = 16'($urandom);

            write_reg(lcf_pkg::REG_ENABLE,     {15'($urandom), en});
            write_reg(lcf_pkg::REG_FADE_DELAY, {8'($urandom), delay_v});
            write_reg(lcf_pkg::REG_RING_SPEED, {8'($urandom), speed_v});
            write_reg(lcf_pkg::REG_FADE_RATE,  rate_v);
            write_reg(lcf_pkg::REG_SEED_RED,   {8'($urandom), pick_seed()});
            write_reg(lcf_pkg::REG_SEED_GREEN, {8'($urandom), pick_seed()});
            write_reg(lcf_pkg::REG_SEED_BLUE,  {8'($urandom), pick_seed()});

            @(negedge i_clk);
            if (!en) begin
                // a short burst that the block must ignore
                for (int i = 0; i < 8; i++) begin
                    pending_ticks.push_back(1'($urandom));
                end
                sent_total += 8;
            end else begin
                for (int i = 0; i < CHUNK_TICKS; i++) begin
                    t = ($urandom_range(0, 99) < 85);
                    pending_ticks.push_back(t);
                end
                sent_total += CHUNK_TICKS;
            end
            settle();
            chunk++;
        end

        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #120000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
